// ===== sv/background_diff_threshold_median3_macros.svh =====
// Assertion macros for the background difference mask block.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef BACKGROUND_DIFF_THRESHOLD_MEDIAN3_MACROS_SVH
`define BACKGROUND_DIFF_THRESHOLD_MEDIAN3_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside of reset.
`define BDTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside of reset.
`define BDTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BDTM_ASSERT_NOW(label, ante, cons)
`define BDTM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/bdtm_pkg.sv =====
`timescale 1ns / 1ps

package bdtm_pkg;

  // Frame geometry and field widths.
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned MAX_WIDTH  = 2 ** COORD_W;
  localparam int unsigned MAX_HEIGHT = 2 ** COORD_W;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register indexes of the configuration port.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DIFF_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_FRAME_WIDTH    = 2'd1;
  localparam cfg_idx_t CFG_FRAME_HEIGHT   = 2'd2;

  // Register values after reset.
  localparam logic [PIX_W-1:0]  RST_DIFF_THRESHOLD = 8'd30;
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH    = 11'd320;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT   = 11'd240;

  // Mask output levels.
  localparam logic [PIX_W-1:0] MASK_FG = 8'd255;
  localparam logic [PIX_W-1:0] MASK_BG = 8'd0;

  // Result slots of one job, in emission order.
  localparam int unsigned SLOT_UP_LEFT = 0;  // (r-1, c-1)
  localparam int unsigned SLOT_LEFT    = 1;  // (r,   c-1), bottom row only
  localparam int unsigned SLOT_UP      = 2;  // (r-1, c),   right column only
  localparam int unsigned SLOT_HERE    = 3;  // (r,   c),   last pixel of frame
  localparam int unsigned NUM_SLOTS    = 4;

  typedef struct packed {
    logic [PIX_W-1:0]  diff_threshold;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] emit;
    logic [NUM_SLOTS-1:0] vote;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
  } job_t;

  // Last valid index of a dimension after saturating the size to 2..max.
  function automatic logic [COORD_W-1:0] size_last(logic [SIZE_W-1:0] raw,
                                                   int unsigned max_size);
    logic [SIZE_W-1:0] t;
    if (raw < SIZE_W'(2)) begin
      t = SIZE_W'(1);
    end else if (raw > SIZE_W'(max_size)) begin
      t = SIZE_W'(max_size - 1);
    end else begin
      t = raw - SIZE_W'(1);
    end
    return t[COORD_W-1:0];
  endfunction

  // Column of three mask bits shifted one row down, with the bottom row replicated.
  function automatic logic [2:0] drop_top(logic [2:0] c);
    return {c[2], c[2], c[1]};
  endfunction

  // Median of nine binary pixels: at least five set.
  function automatic logic majority(logic [8:0] bits);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      n = n + {3'b000, bits[i]};
    end
    return n >= 4'd5;
  endfunction

endpackage

// ===== sv/bdtm_front.sv =====
`timescale 1ns / 1ps

module bdtm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdtm_pkg::cfg_t            cfg_i,
  input  logic                      restart_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bdtm_pkg::PIX_W-1:0] frame_pixel_i,
  input  logic [bdtm_pkg::PIX_W-1:0] background_pixel_i,
  output logic                      job_valid_o,
  output bdtm_pkg::job_t            job_o,
  input  logic                      job_full_i
);
  import bdtm_pkg::*;

  // Line stores of mask bits for the two previous rows.
  logic line_above_mem     [MAX_WIDTH];
  logic line_two_above_mem [MAX_WIDTH];

  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_W-1:0] w_last, h_last;
  logic [PIX_W-1:0]   diff;
  logic               fg, accept;

  logic               s1_valid_q, s1_valid_d;
  logic               s1_fg_q, s1_last_row_q, s1_last_col_q;
  logic [COORD_W-1:0] s1_col_q, s1_row_q;
  logic               mid_rd_q, two_rd_q;
  logic [8:0]         win_q, win_d;
  logic               advance;

  logic [2:0]           col_bits, c0, c1, c2;
  logic [NUM_SLOTS-1:0] emit, vote;
  logic                 has_up;

  assign w_last = size_last(cfg_i.frame_width, MAX_WIDTH);
  assign h_last = size_last(cfg_i.frame_height, MAX_HEIGHT);

  // Stage 0: classify the pixel against the background.
  assign diff = (frame_pixel_i > background_pixel_i) ? frame_pixel_i - background_pixel_i
                                                    : background_pixel_i - frame_pixel_i;
  assign fg = diff > cfg_i.diff_threshold;

  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // Raster position of the next item.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = (row_q == h_last) ? '0 : row_q + COORD_W'(1);
      end else begin
        col_d = col_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store reads on accept; writes when the item leaves stage 1.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q <= line_above_mem[col_q];
      two_rd_q <= line_two_above_mem[col_q];
    end
    if (advance) begin
      line_above_mem[s1_col_q]     <= s1_fg_q;
      line_two_above_mem[s1_col_q] <= mid_rd_q;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_fg_q       <= fg;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_last_col_q <= col_q == w_last;
      s1_last_row_q <= row_q == h_last;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage 1: build the window column; rows above the frame repeat row 0.
  assign col_bits = {s1_fg_q, mid_rd_q, (s1_row_q <= COORD_W'(1)) ? mid_rd_q : two_rd_q};
  assign win_d    = (s1_col_q == '0) ? {col_bits, col_bits, col_bits}
                                     : {col_bits, win_q[8:3]};
  assign c0 = win_d[2:0];
  assign c1 = win_d[5:3];
  assign c2 = win_d[8:6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart_i) begin
      win_q <= '0;
    end else if (advance) begin
      win_q <= win_d;
    end
  end

  // Majority votes for the four result positions this pixel can finish.
  assign vote[SLOT_UP_LEFT] = majority({c2, c1, c0});
  assign vote[SLOT_LEFT]    = majority({drop_top(c2), drop_top(c1), drop_top(c0)});
  assign vote[SLOT_UP]      = majority({c2, c2, c1});
  assign vote[SLOT_HERE]    = majority({drop_top(c2), drop_top(c2), drop_top(c1)});

  assign has_up              = s1_row_q != '0;
  assign emit[SLOT_UP_LEFT]  = has_up && (s1_col_q != '0);
  assign emit[SLOT_LEFT]     = emit[SLOT_UP_LEFT] && s1_last_row_q;
  assign emit[SLOT_UP]       = has_up && s1_last_col_q;
  assign emit[SLOT_HERE]     = emit[SLOT_UP] && s1_last_row_q;

  // A pixel that finishes nothing leaves without a queue slot.
  assign advance     = s1_valid_q && ((emit == '0) || !job_full_i);
  assign job_valid_o = s1_valid_q && (emit != '0) && !job_full_i;

  assign job_o.emit = emit;
  assign job_o.vote = vote;
  assign job_o.row  = s1_row_q;
  assign job_o.col  = s1_col_q;

endmodule

// ===== sv/bdtm_queue.sv =====
`timescale 1ns / 1ps

module bdtm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bdtm_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bdtm_pkg::job_t head_o
);
  import bdtm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/bdtm_back.sv =====
`timescale 1ns / 1ps

module bdtm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  bdtm_pkg::job_t                job_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdtm_pkg::PIX_W-1:0]    mask_pixel_o,
  output logic [bdtm_pkg::COORD_W-1:0]  out_row_o,
  output logic [bdtm_pkg::COORD_W-1:0]  out_col_o,
  output logic                          frame_done_o
);
  import bdtm_pkg::*;

  logic [NUM_SLOTS-1:0] used_q, used_d, pending, sel;
  logic                 load, last;
  logic                 out_valid_q, out_valid_d;
  logic [PIX_W-1:0]     mask_q;
  logic [COORD_W-1:0]   row_q, col_q;
  logic                 done_q;

  // Pick the earliest result of the head job not yet sent.
  assign pending = job_i.emit & ~used_q;
  assign sel     = pending & (~pending + NUM_SLOTS'(1));
  assign last    = (pending & ~sel) == '0;
  assign load    = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = load && last;

  always_comb begin
    used_d = used_q;
    if (load) begin
      used_d = last ? '0 : (used_q | sel);
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_q <= ((sel & job_i.vote) != '0) ? MASK_FG : MASK_BG;
      row_q  <= (sel[SLOT_UP_LEFT] || sel[SLOT_UP]) ? job_i.row - COORD_W'(1) : job_i.row;
      col_q  <= (sel[SLOT_UP_LEFT] || sel[SLOT_LEFT]) ? job_i.col - COORD_W'(1) : job_i.col;
      done_q <= sel[SLOT_HERE];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mask_pixel_o = mask_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign frame_done_o = done_q;

endmodule

// ===== sv/background_diff_threshold_median3.sv =====
// Foreground mask from background difference, cleaned by a 3x3 binary median.
// Input channel: in_valid_i/in_ready_o with one frame pixel and its background
// pixel per item, in raster order. Output channel: out_valid_o/out_ready_i with
// one mask pixel (0 or 255), its row and column, and frame_done on the last one.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data; it is
// always ready. Writing frame width or height restarts the frame position.
// Throughput: one pixel per cycle while the job queue has room. Each row after
// the first gives one result per pixel on average (none at the left column, two
// at the right column); the bottom row gives two per pixel, so there the output
// port, one result per cycle, halves the input rate.
// The first result of pixel (r, c), the one for (r-1, c-1), goes from the stage 1
// register, which also holds the line store reads, through the job queue into the
// output register. A four-entry job queue lets the front keep accepting while the
// receiver stalls; when it is full, in_ready_o drops once the stage 1 pixel needs
// a slot. Reset clears the position, window, queue and output; the line stores
// need no clearing since the top row replicates itself and no stale entry ever
// reaches a result.
`timescale 1ns / 1ps

`include "background_diff_threshold_median3_macros.svh"

module background_diff_threshold_median3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bdtm_pkg::PIX_W-1:0]      frame_pixel_i,
  input  logic [bdtm_pkg::PIX_W-1:0]      background_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bdtm_pkg::PIX_W-1:0]      mask_pixel_o,
  output logic [bdtm_pkg::COORD_W-1:0]    out_row_o,
  output logic [bdtm_pkg::COORD_W-1:0]    out_col_o,
  output logic                            frame_done_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bdtm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bdtm_pkg::SIZE_W-1:0]     cfg_data_i
);
  import bdtm_pkg::*;

  cfg_t   cfg_q;
  logic   cfg_write, restart;
  logic   job_valid, job_full, job_pop, head_valid;
  job_t   job, head;
  logic [COORD_W-1:0] w_last, h_last;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_write &&
                       (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diff_threshold <= RST_DIFF_THRESHOLD;
      cfg_q.frame_width    <= RST_FRAME_WIDTH;
      cfg_q.frame_height   <= RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_DIFF_THRESHOLD: cfg_q.diff_threshold <= cfg_data_i[PIX_W-1:0];
        CFG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i;
        CFG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bdtm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .restart_i          (restart),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .frame_pixel_i      (frame_pixel_i),
    .background_pixel_i (background_pixel_i),
    .job_valid_o        (job_valid),
    .job_o              (job),
    .job_full_i         (job_full)
  );

  bdtm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i (job),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  bdtm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (head_valid),
    .job_i        (head),
    .job_pop_o    (job_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mask_pixel_o (mask_pixel_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_done_o (frame_done_o)
  );

  // Frame limits, used by the checks below.
  assign w_last = size_last(cfg_q.frame_width, MAX_WIDTH);
  assign h_last = size_last(cfg_q.frame_height, MAX_HEIGHT);

  // The frame end marker sits only on the bottom right pixel.
  `BDTM_ASSERT_NOW(a_done_corner, out_valid_o && frame_done_o,
                   out_row_o == h_last && out_col_o == w_last)

  // Every emitted pixel lies inside the frame.
  `BDTM_ASSERT_NOW(a_in_frame, out_valid_o, out_row_o <= h_last && out_col_o <= w_last)

  // The mask is binary.
  `BDTM_ASSERT_NOW(a_mask_binary, out_valid_o,
                   mask_pixel_o == MASK_FG || mask_pixel_o == MASK_BG)

  // A full queue never takes a job.
  `BDTM_ASSERT_NOW(a_no_overflow, job_full, !job_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SETTLE_CYCLES = 8;     // Pipeline depth plus margin.
  localparam int unsigned IDLE_LIMIT    = 2000;  // Cycles without any handshake.
  localparam int unsigned REPORT_LIMIT  = 100;
  localparam bdtm_pkg::cfg_idx_t CFG_UNMAPPED = 2'd3;

  typedef logic [bdtm_pkg::PIX_W-1:0]   pix_t;
  typedef logic [bdtm_pkg::COORD_W-1:0] coord_t;
  typedef logic [bdtm_pkg::SIZE_W-1:0]  size_t;

  typedef struct packed {
    pix_t   mask;
    coord_t row;
    coord_t col;
    logic   done;
  } mask_px_t;

  // Tracks the mask pipeline: line stores, window and raster position.
  class mask_tracker;
    pix_t        threshold;
    size_t       width_raw;
    size_t       height_raw;
    bit          above_row [bdtm_pkg::MAX_WIDTH];
    bit          two_above_row [bdtm_pkg::MAX_WIDTH];
    logic [8:0]  window;
    int unsigned next_col;
    int unsigned next_row;
    mask_px_t    due_masks[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned frames;
    int unsigned pixels;
    int unsigned reg_writes;
    int unsigned reports;

    function new();
      threshold  = bdtm_pkg::RST_DIFF_THRESHOLD;
      width_raw  = bdtm_pkg::RST_FRAME_WIDTH;
      height_raw = bdtm_pkg::RST_FRAME_HEIGHT;
      window     = '0;
      next_col   = 0;
      next_row   = 0;
    endfunction

    function int unsigned saturate(size_t raw, int unsigned hi);
      if (raw < 2) return 2;
      if (raw > hi) return hi;
      return raw;
    endfunction

    // Binary median: foreground when at least five of nine bits are set.
    function pix_t vote(logic [2:0] a, logic [2:0] b, logic [2:0] c);
      return ($countones({c, b, a}) >= 5) ? bdtm_pkg::MASK_FG : bdtm_pkg::MASK_BG;
    endfunction

    // Column seen one row lower, with the bottom row replicated.
    function logic [2:0] below(logic [2:0] v);
      return {v[2], v[2], v[1]};
    endfunction

    function void expect_mask(pix_t m, int unsigned r, int unsigned c, logic d);
      due_masks.push_back('{mask: m, row: coord_t'(r), col: coord_t'(c), done: d});
    endfunction

    function void write_reg(bdtm_pkg::cfg_idx_t idx, size_t data);
      reg_writes++;
      case (idx)
        bdtm_pkg::CFG_DIFF_THRESHOLD: threshold = data[bdtm_pkg::PIX_W-1:0];
        bdtm_pkg::CFG_FRAME_WIDTH, bdtm_pkg::CFG_FRAME_HEIGHT: begin
          if (idx == bdtm_pkg::CFG_FRAME_WIDTH) width_raw = data;
          else height_raw = data;
          // A size write restarts the frame; the line stores are kept.
          next_col = 0;
          next_row = 0;
          window   = '0;
        end
        default: ;
      endcase
    endfunction

    // One accepted pixel: update the state and queue the masks it releases.
    function void note_pixel(pix_t fp, pix_t bp);
      int unsigned w, h, c, r, diff;
      bit          fg, mid, top, last_row, last_col;
      logic [2:0]  column, c0, c1, c2;
      w = saturate(width_raw, bdtm_pkg::MAX_WIDTH);
      h = saturate(height_raw, bdtm_pkg::MAX_HEIGHT);
      diff = (fp > bp) ? fp - bp : bp - fp;
      fg = diff > threshold;
      c = (next_col >= w) ? w - 1 : next_col;
      r = (next_row >= h) ? h - 1 : next_row;
      last_row = (r == h - 1);
      last_col = (c == w - 1);
      pixels++;

      // Rows 0 and 1 repeat the row above in place of the row two above.
      mid = above_row[c];
      top = (r <= 1) ? mid : two_above_row[c];
      two_above_row[c] = mid;
      above_row[c] = fg;
      column = {fg, mid, top};
      window = (c == 0) ? {column, column, column} : {column, window[8:3]};
      c0 = window[2:0];
      c1 = window[5:3];
      c2 = window[8:6];

      // The bottom row emits its own pixels right after those of the row above.
      if (r >= 1 && c >= 1) begin
        expect_mask(vote(c0, c1, c2), r - 1, c - 1, 1'b0);
        if (last_row) expect_mask(vote(below(c0), below(c1), below(c2)), r, c - 1, 1'b0);
      end
      if (r >= 1 && last_col) begin
        expect_mask(vote(c1, c2, c2), r - 1, c, 1'b0);
        if (last_row) expect_mask(vote(below(c1), below(c2), below(c2)), r, c, 1'b1);
      end

      if (last_col) begin
        next_col = 0;
        next_row = last_row ? 0 : r + 1;
      end else begin
        next_col = c + 1;
        next_row = r;
      end
    endfunction

    function void complain(string field, mask_px_t want, logic [15:0] exp, logic [15:0] act);
      errors++;
      if (reports < REPORT_LIMIT) begin
        $display("%0t: %s at row %0d col %0d: expected %0d, got %0d",
                 $time, field, want.row, want.col, exp, act);
      end
      reports++;
    endfunction

    // One accepted mask pixel against the oldest one due.
    function void check_mask(mask_px_t got);
      mask_px_t want;
      if (due_masks.size() == 0) begin
        errors++;
        if (reports < REPORT_LIMIT) begin
          $display("%0t: mask pixel with none due: expected nothing, got row %0d col %0d value %0d",
                   $time, got.row, got.col, got.mask);
        end
        reports++;
      end else begin
        want = due_masks.pop_front();
        checked++;
        if (got.done === 1'b1) frames++;
        if (got.mask !== want.mask) complain("mask_pixel", want, 16'(want.mask), 16'(got.mask));
        if (got.row !== want.row) complain("out_row", want, 16'(want.row), 16'(got.row));
        if (got.col !== want.col) complain("out_col", want, 16'(want.col), 16'(got.col));
        if (got.done !== want.done) complain("frame_done", want, 16'(want.done), 16'(got.done));
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  pix_t   frame_pixel_i;
  pix_t   background_pixel_i;
  logic   out_valid_o;
  logic   out_ready_i;
  pix_t   mask_pixel_o;
  coord_t out_row_o;
  coord_t out_col_o;
  logic   frame_done_o;
  logic   cfg_valid_i;
  logic   cfg_ready_o;
  bdtm_pkg::cfg_idx_t cfg_index_i;
  size_t  cfg_data_i;

  mask_tracker masks;
  bit          calm;
  int unsigned idle_cycles = 0;

  background_diff_threshold_median3 DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .frame_pixel_i      (frame_pixel_i),
    .background_pixel_i (background_pixel_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .mask_pixel_o       (mask_pixel_o),
    .out_row_o          (out_row_o),
    .out_col_o          (out_col_o),
    .frame_done_o       (frame_done_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver side: random stall bursts, none once the run turns calm.
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Handshake monitor; every accepted item goes to the tracker.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) masks.note_pixel(frame_pixel_i, background_pixel_i);
      if (out_valid_o && out_ready_i) begin
        masks.check_mask('{mask: mask_pixel_o, row: out_row_o, col: out_col_o,
                           done: frame_done_o});
      end
      if (cfg_valid_i && cfg_ready_o) masks.write_reg(cfg_index_i, cfg_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog: ends a run that has stopped moving.
  initial begin
    do @(posedge clk_i); while (idle_cycles < IDLE_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Sender: optional gap, then hold the item until it is taken.
  task automatic send_pixel(pix_t fp, pix_t bp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    frame_pixel_i      <= fp;
    background_pixel_i <= bp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending until every due mask pixel has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (masks.due_masks.size() != 0);
  endtask

  // Drain, then let pixels that release no result clear the pipeline.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A held valid stays high into the next write of a burst.
  task automatic write_reg(bdtm_pkg::cfg_idx_t idx, size_t data, bit hold);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (!hold) cfg_valid_i <= 1'b0;
  endtask

  task automatic setup_frame(size_t thr, size_t w, size_t h);
    settle();
    write_reg(bdtm_pkg::CFG_DIFF_THRESHOLD, thr, 1'b1);
    write_reg(bdtm_pkg::CFG_FRAME_WIDTH, w, 1'b1);
    write_reg(bdtm_pkg::CFG_FRAME_HEIGHT, h, 1'b0);
  endtask

  // Pixel pair that is foreground with the given chance in percent, apart from an occasional fully random pair.
  function automatic void pick_pixel(int unsigned density, output pix_t fp, output pix_t bp);
    int unsigned thr, d, b;
    thr = masks.threshold;
    if ($urandom_range(0, 7) == 0) begin
      fp = pix_t'($urandom_range(0, 255));
      bp = pix_t'($urandom_range(0, 255));
    end else begin
      if ($urandom_range(1, 100) <= density && thr < 255) d = $urandom_range(thr + 1, 255);
      else d = $urandom_range(0, thr);
      if ($urandom_range(0, 1) == 1) begin
        b  = $urandom_range(0, 255 - d);
        fp = pix_t'(b + d);
      end else begin
        b  = $urandom_range(d, 255);
        fp = pix_t'(b - d);
      end
      bp = pix_t'(b);
    end
  endfunction

  task automatic feed(int unsigned count, int unsigned density);
    pix_t fp, bp;
    repeat (count) begin
      pick_pixel(density, fp, bp);
      send_pixel(fp, bp);
    end
  endtask

  // Small frames with random settings; some are cut short mid-frame.
  task automatic random_frames(int unsigned target);
    int unsigned sent, w, h, n, density;
    size_t       thr;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < target) begin
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 8);
      case ($urandom_range(0, 5))
        0:       thr = 11'd0;
        1:       thr = 11'd255;
        2:       thr = size_t'($urandom_range(0, 2047));
        default: thr = size_t'($urandom_range(1, 254));
      endcase
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, w * h - 1);
      density = $urandom_range(10, 90);
      if ($urandom_range(0, 7) == 0) begin
        settle();
        write_reg(CFG_UNMAPPED, size_t'($urandom_range(0, 2047)), 1'b0);
      end
      setup_frame(thr, size_t'(w), size_t'(h));
      if (!paused && n > 2) begin
        // Once, the sender waits mid-frame for the output to catch up.
        feed(n / 2, density);
        drain();
        feed(n - n / 2, density);
        paused = 1'b1;
      end else begin
        feed(n, density);
      end
      sent += n;
    end
  endtask

  initial begin
    logic [15:0] corner_px [9];
    masks = new();
    corner_px = '{16'h0000, 16'hFF00, 16'h00FF, 16'h0100, 16'h0001,
                  16'hFFFF, 16'h807F, 16'h0000, 16'hFF00};
    calm               = 1'b0;
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    frame_pixel_i      <= '0;
    background_pixel_i <= '0;
    cfg_valid_i        <= 1'b0;
    cfg_index_i        <= bdtm_pkg::CFG_DIFF_THRESHOLD;
    cfg_data_i         <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a bit over one row of 320, so the second row releases masks.
    feed(330, 50);

    // Threshold 0 on a 3x3 frame: differences of 0 and 1, full range values.
    setup_frame(11'd0, 11'd3, 11'd3);
    foreach (corner_px[i]) send_pixel(corner_px[i][15:8], corner_px[i][7:0]);

    // Threshold 255 never marks foreground; sizes 0 and 1 saturate to 2.
    setup_frame(11'd255, 11'd0, 11'd1);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd0);

    // Threshold data above 8 bits is cut; a write to an unmapped index changes nothing.
    settle();
    write_reg(bdtm_pkg::CFG_DIFF_THRESHOLD, 11'h4FE, 1'b1);
    write_reg(CFG_UNMAPPED, 11'h7FF, 1'b1);
    write_reg(bdtm_pkg::CFG_FRAME_WIDTH, 11'd2, 1'b1);
    write_reg(bdtm_pkg::CFG_FRAME_HEIGHT, 11'd3, 1'b0);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd1);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd1, 8'd255);

    random_frames(80);

    // Last part runs at full rate on both sides.
    calm = 1'b1;
    random_frames(30);

    settle();
    $display("Run covered %0d pixels, %0d mask pixels checked, %0d frames, %0d register writes,",
             masks.pixels, masks.checked, masks.frames, masks.reg_writes);
    $display("with frame sizes from 2 to 320, thresholds 0 to 255 and stalls on both sides.");
    if (masks.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", masks.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
